/* hdl/slt_pkg.sv */
// Package for the selectable list table: default sizes, operation codes and
// the control struct broadcast from the top level to the row of entry cells.
// No dependencies.
package slt_pkg;

    localparam int unsigned SLT_DEPTH       = 16;
    localparam int unsigned SLT_VALUE_WIDTH = 32;

    // operation carried in the input tuser
    typedef enum logic [1:0] {
        MODE_APPEND     = 2'd0,
        MODE_REMOVE     = 2'd1,
        MODE_SEL_INDEX  = 2'd2,
        MODE_SEL_VALUE  = 2'd3
    } mode_t;

    // committed update, same for every cell
    typedef struct packed {
        logic load;   // append takes effect; cell at position == count loads
        logic shift;  // remove takes effect; cells at or above index shift down
    } cell_ctl_t;

endpackage

/* hdl/slt_cell.sv */
// One entry cell of the selectable list table: holds one stored value,
// loads on append, takes its upper neighbor's value on remove, and takes
// part in the first-match search chain. Depends on slt_pkg.
module slt_cell
    import slt_pkg::*;
#(
    parameter int unsigned DEPTH       = SLT_DEPTH,
    parameter int unsigned VALUE_WIDTH = SLT_VALUE_WIDTH,
    parameter int unsigned POS         = 0
)
(
    input  logic                             clk,
    input  cell_ctl_t                        ctl,
    input  logic [$clog2(DEPTH+1)-1:0]       cnt,
    input  logic [$clog2(DEPTH)-1:0]         idx,
    input  logic [VALUE_WIDTH-1:0]           value,
    input  logic [VALUE_WIDTH-1:0]           upper,
    input  logic                             found_in,
    output logic                             found_out,
    output logic [VALUE_WIDTH-1:0]           entry,
    output logic [VALUE_WIDTH-1:0]           rd,
    output logic [$clog2(DEPTH)-1:0]         pos
);

    localparam int unsigned CW   = $clog2(DEPTH);
    localparam int unsigned CNTW = $clog2(DEPTH+1);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   live;
    logic                   hit;
    logic                   first;

    assign live = CNTW'(POS) < cnt;
    assign hit  = live && (entry_reg == value);

    // first match: no hit in any lower cell
    assign first     = hit && !found_in;
    assign found_out = found_in || hit;

    assign pos   = first ? CW'(POS) : '0;
    assign rd    = (idx == CW'(POS)) ? entry_reg : '0;
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load && (cnt == CNTW'(POS)))
        begin
            entry_next = value;
        end
        else if (ctl.shift && (idx <= CW'(POS)))
        begin
            entry_next = upper;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* hdl/selectable_list_table.sv */
// Top level of the selectable list table: stream ports, count/cursor state,
// operation decode, the row of slt_cell entries and the output register.
// Depends on slt_pkg and slt_cell.
//
//   port group | dir | fields (low bit first)
//   -----------+-----+--------------------------------------------------
//   s_*        | in  | tuser: mode[1:0]; tdata: index[3:0], value[35:4]
//   m_*        | out | tdata: ok[0], selected_value[32:1], cursor[36:33],
//              |     |        count[41:37], zero fill [47:42]
//
// One operation per clock: every cell updates in the same cycle (append
// load, shift-down on remove, parallel compare for select-by-value), so the
// cell row sets the rate at one beat per cycle while s_tready is high; a
// result appears in the output register in the cycle after its input beat.
// Reset (rst_n low) empties the list: count 0, cursor 0, no result pending.
// Stored entries are not cleared; only slots below count are ever read.
// A stalled output holds its beat; s_tready stays high while the output
// register is empty or being drained in the same cycle.
module selectable_list_table
    import slt_pkg::*;
#(
    parameter int unsigned DEPTH       = SLT_DEPTH,
    parameter int unsigned VALUE_WIDTH = SLT_VALUE_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // index[3:0], value[35:4], zero [39:36]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // ok[0], selected_value[32:1], cursor[36:33],
                                   // count[41:37], zero [47:42]
);

    localparam int unsigned CW   = $clog2(DEPTH);
    localparam int unsigned CNTW = $clog2(DEPTH+1);
    // common width for comparing the 4-bit index and 5-bit count fields
    localparam int unsigned XW   = (CNTW > 5) ? CNTW : 5;

    // list state
    logic [CNTW-1:0]        cnt_reg;
    logic [CNTW-1:0]        cnt_next;
    logic [CW-1:0]          cur_reg;
    logic [CW-1:0]          cur_next;
    logic [VALUE_WIDTH-1:0] sel_reg;    // value under the cursor, 0 when empty
    logic [VALUE_WIDTH-1:0] sel_next;

    // output register
    logic                   m_tvalid_reg;
    logic [47:0]            m_tdata_reg;
    logic [47:0]            m_tdata_next;

    // decoded input beat
    mode_t                  mode;
    logic [3:0]             s_index;
    logic [31:0]            s_value;
    logic [VALUE_WIDTH-1:0] v_in;
    logic [XW-1:0]          idx_x;
    logic [XW-1:0]          cnt_x;
    logic [XW-1:0]          cur_x;
    logic [XW-1:0]          cnt_nx;
    logic [XW-1:0]          cur_nx;
    logic [CW-1:0]          idx_c;
    logic                   idx_in_range;
    logic                   not_full;
    logic                   fire;
    logic                   ok;
    cell_ctl_t              ctl;

    // cell row
    logic [VALUE_WIDTH-1:0] entry_q [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_q    [DEPTH];
    logic [CW-1:0]          pos_q   [DEPTH];
    logic [DEPTH:0]         found;
    logic [VALUE_WIDTH-1:0] rd_any;
    logic [CW-1:0]          pos_any;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign mode    = mode_t'(s_tuser[1:0]);
    assign s_index = s_tdata[3:0];
    assign s_value = s_tdata[35:4];
    assign v_in    = VALUE_WIDTH'(s_value);

    assign idx_x = XW'(s_index);
    assign cnt_x = XW'(cnt_reg);
    assign cur_x = XW'(cur_reg);
    // only used when the index is below count, so it fits the cursor width
    assign idx_c = CW'(idx_x);

    assign idx_in_range = idx_x < cnt_x;
    assign not_full     = cnt_x < XW'(DEPTH);

    // search chain starts clear at cell 0
    assign found[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] upper;

        if (g == DEPTH - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = entry_q[g+1];
        end

        slt_cell #(
            .DEPTH       (DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .POS         (g)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .cnt       (cnt_reg),
            .idx       (idx_c),
            .value     (v_in),
            .upper     (upper),
            .found_in  (found[g]),
            .found_out (found[g+1]),
            .entry     (entry_q[g]),
            .rd        (rd_q[g]),
            .pos       (pos_q[g])
        );
    end

    // at most one cell drives a nonzero read value and a nonzero position
    always_comb
    begin
        rd_any  = '0;
        pos_any = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_any  = rd_any | rd_q[i];
            pos_any = pos_any | pos_q[i];
        end
    end

    always_comb
    begin
        ok        = 1'b0;
        ctl       = '0;
        cnt_next  = cnt_reg;
        cur_next  = cur_reg;
        sel_next  = sel_reg;
        case (mode)
            MODE_APPEND:
            begin
                if (not_full)
                begin
                    ok        = 1'b1;
                    ctl.load  = fire;
                    cnt_next  = cnt_reg + CNTW'(1);
                    // first entry becomes the selection at position 0
                    if (cnt_reg == '0)
                    begin
                        sel_next = v_in;
                    end
                end
            end
            MODE_REMOVE:
            begin
                if (idx_in_range)
                begin
                    ok        = 1'b1;
                    ctl.shift = fire;
                    cnt_next  = cnt_reg - CNTW'(1);
                    if (idx_x == cur_x)
                    begin
                        // selected entry removed: cursor back to the head
                        cur_next = '0;
                        if (cnt_reg == CNTW'(1))
                        begin
                            sel_next = '0;
                        end
                        else if (idx_c == '0)
                        begin
                            sel_next = entry_q[1];
                        end
                        else
                        begin
                            sel_next = entry_q[0];
                        end
                    end
                    else if (idx_c < cur_reg)
                    begin
                        cur_next = cur_reg - CW'(1);
                    end
                end
            end
            MODE_SEL_INDEX:
            begin
                if (idx_in_range)
                begin
                    ok       = 1'b1;
                    cur_next = idx_c;
                    sel_next = rd_any;
                end
            end
            MODE_SEL_VALUE:
            begin
                if (found[DEPTH])
                begin
                    ok       = 1'b1;
                    cur_next = pos_any;
                    sel_next = v_in;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign cnt_nx = XW'(cnt_next);
    assign cur_nx = XW'(cur_next);

    assign m_tdata_next = {6'd0, cnt_nx[4:0], cur_nx[3:0], 32'(sel_next), ok};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            cur_reg      <= '0;
            sel_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                cnt_reg      <= cnt_next;
                cur_reg      <= cur_next;
                sel_reg      <= sel_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

/* test/selectable_list_table_test.sv */
// Self-checking testbench for selectable_list_table: a short directed run, then random list
// traffic with bursty input and a patterned output stall, all checked against a predictor.
// Depends on slt_pkg and the selectable_list_table RTL.
module selectable_list_table_test;
    import slt_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 4000;  // cycles with no beat on either side
    localparam int unsigned RANDOM_ITEMS = 550;
    localparam int unsigned REPORT_MAX   = 10;

    // result beat fields, packed to match m_tdata[41:0] (ok in bit 0)
    typedef struct packed {
        logic [4:0]  count;
        logic [3:0]  cursor;
        logic [31:0] sel_value;
        logic        ok;
    } list_result_t;

    // Predictor of the list plus the queue of results still owed by the block.
    class list_scoreboard;
        logic [31:0]  entries [SLT_DEPTH];
        int unsigned  count;
        int unsigned  cursor;
        list_result_t owed_q [$];
        int unsigned  mismatches;

        function new();
            foreach (entries[i])
            begin
                entries[i] = '0;
            end
            count      = 0;
            cursor     = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        // apply one accepted operation and queue the result it must produce
        function void note_op(mode_t mode, logic [3:0] index, logic [31:0] value);
            list_result_t res;
            int unsigned  i;
            logic         ok;
            ok = 1'b0;
            case (mode)
                MODE_APPEND:
                begin
                    if (count < SLT_DEPTH)
                    begin
                        entries[count] = value;
                        count++;
                        ok = 1'b1;
                    end
                end
                MODE_REMOVE:
                begin
                    if (index < count)
                    begin
                        if (cursor == index)
                            cursor = 0;
                        else if (index < cursor)
                            cursor--;
                        for (i = 32'(index); i + 1 < count; i++)
                            entries[i] = entries[i + 1];
                        entries[count - 1] = '0;
                        count--;
                        ok = 1'b1;
                    end
                end
                MODE_SEL_INDEX:
                begin
                    if (index < count)
                    begin
                        cursor = 32'(index);
                        ok     = 1'b1;
                    end
                end
                default:
                begin
                    // first match wins
                    for (i = 0; i < count && !ok; i++)
                    begin
                        if (entries[i] == value)
                        begin
                            cursor = i;
                            ok     = 1'b1;
                        end
                    end
                end
            endcase
            res.ok        = ok;
            res.sel_value = (count > 0) ? entries[cursor] : '0;
            res.cursor    = cursor[3:0];
            res.count     = count[4:0];
            owed_q = {owed_q, res};
        endfunction

        function void check_result(logic [47:0] beat);
            list_result_t got;
            list_result_t want;
            got = beat[41:0];
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] unexpected result beat %h", $realtime, beat);
                return;
            end
            want = owed_q.pop_front();
            if (got.ok !== want.ok || got.sel_value !== want.sel_value ||
                got.cursor !== want.cursor || got.count !== want.count)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("[%0t] mismatch: expected ok=%0d sel=%h cur=%0d cnt=%0d",
                             $realtime, want.ok, want.sel_value, want.cursor, want.count);
                    $display("    got ok=%0d sel=%h cur=%0d cnt=%0d",
                             got.ok, got.sel_value, got.cursor, got.count);
                end
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // index[3:0], value[35:4], zero [39:36]
    logic [1:0]  s_tuser  = '0;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // ok[0], selected_value[32:1], cursor[36:33],
                                  // count[41:37], zero [47:42]

    list_scoreboard sb;
    int unsigned    burst_left = 0;
    int unsigned    idle_cycles = 0;
    int unsigned    stall_cycle = 0;
    int unsigned    stall_style = 0;

    selectable_list_table dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall_cycle sets when a new stall style is picked - always ready,
    // light stalls, heavy stalls, or ready alternating from cycle to cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            stall_cycle <= stall_cycle + 1;
            if (stall_cycle % 64 == 0)
                stall_style <= $urandom_range(0, 3);
            case (stall_style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= stall_cycle[0];
            endcase
        end
    end

    // Monitor: inputs are noted before outputs are checked, so a result that
    // shares an edge with its own beat would still find its expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_op(mode_t'(s_tuser), s_tdata[3:0], s_tdata[35:4]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Watchdog: a run that stops moving beats for too long is a failure.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive one operation beat and return at the edge that accepts it.
    // Beats go out in bursts; between bursts tvalid may drop for a random gap.
    task automatic send_op(mode_t mode, logic [3:0] index, logic [31:0] value);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0000, value, index};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Directed: empty-list corner cases, fill to capacity with extreme and
    // duplicate values, append when full, and each way a removal moves the cursor.
    task automatic run_directed();
        logic [31:0] fill_vals [16] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                                        32'h5555_5555, 32'h8000_0000, 32'h0000_0001,
                                        32'h0000_0000, 32'h1234_5678, 32'h7FFF_FFFF,
                                        32'hFFFF_FFFF, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                                        32'h0000_00FF, 32'hCAFE_F00D, 32'h0000_0002,
                                        32'hFEDC_BA98};
        int unsigned i;
        send_op(MODE_SEL_INDEX, 4'd0, 32'h0);          // empty: out of range
        send_op(MODE_SEL_VALUE, 4'd0, 32'h0);          // empty: not found
        send_op(MODE_REMOVE, 4'd0, 32'h0);             // empty: nothing to remove
        for (i = 0; i < 16; i++)
            send_op(MODE_APPEND, i[3:0], fill_vals[i]);
        send_op(MODE_APPEND, 4'hF, 32'h0000_0007);     // full: refused
        send_op(MODE_SEL_VALUE, 4'h0, 32'h0000_0000);  // duplicate, first one wins
        send_op(MODE_SEL_INDEX, 4'hF, 32'h0);          // last slot
        send_op(MODE_REMOVE, 4'hF, 32'h0);             // removes selected: cursor to 0
        send_op(MODE_SEL_INDEX, 4'd5, 32'h0);
        send_op(MODE_REMOVE, 4'd2, 32'h0);             // below cursor: cursor down
        send_op(MODE_REMOVE, 4'd10, 32'h0);            // above cursor: cursor stays
        send_op(MODE_SEL_INDEX, 4'hF, 32'h0);          // beyond count
        send_op(MODE_SEL_VALUE, 4'h0, 32'hDEAD_BEEF);  // not present
        send_op(MODE_SEL_VALUE, 4'h0, 32'hFFFF_FFFF);
    endtask

    // Random: the list swings between filling and draining so every count is
    // visited; most indexes and search values hit live entries, the rest miss.
    // The predictor state may lag the driver by one beat; that only skews aim.
    task automatic run_random(int unsigned n);
        int unsigned k;
        int unsigned roll;
        int unsigned cnt;
        bit          filling;
        mode_t       mode;
        logic [3:0]  index;
        logic [31:0] value;
        filling = 1'b1;
        for (k = 0; k < n; k++)
        begin
            cnt = sb.count;
            if (cnt >= SLT_DEPTH)
                filling = 1'b0;
            else if (cnt <= 1)
                filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 35)
                mode = filling ? MODE_APPEND : MODE_REMOVE;
            else if (roll < 50)
                mode = filling ? MODE_REMOVE : MODE_APPEND;
            else if (roll < 75)
                mode = MODE_SEL_INDEX;
            else
                mode = MODE_SEL_VALUE;
            if (cnt > 0 && $urandom_range(0, 3) != 0)
                index = 4'($urandom_range(0, cnt - 1));
            else
                index = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
                0:       value = $urandom_range(0, 7);   // small set, many duplicates
                1:       value = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            if (mode == MODE_SEL_VALUE && cnt > 0 && $urandom_range(0, 3) != 0)
                value = sb.entries[$urandom_range(0, cnt - 1)];
            send_op(mode, index, value);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RANDOM_ITEMS);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // spare edges after the last owed result catch any stray extra beat
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
